// ----- design/dcm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_pkg
// Shared widths, register indexes, mode codes and types of the motor model.
// ----------------------------------------------------------------------------
package dcm_pkg;

	localparam int VOLT_W   = 16;
	localparam int SPEED_W  = 24;
	localparam int COEF_W   = 32;
	localparam int MODE_W   = 2;
	localparam int CFG_IDX_W = 8;
	localparam int DRIVE_W  = VOLT_W + 2;
	localparam int DRIVE12_W = DRIVE_W + 4;
	localparam int ACC_W    = 58;
	localparam int RND_SH   = 28;
	localparam int Y_W      = ACC_W - RND_SH;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C1   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_C2   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CD   = 8'd3;

	localparam logic [MODE_W-1:0] MODE_FWD_EULER = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BWD_EULER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TUSTIN    = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [COEF_W-1:0] c1;
		logic signed [COEF_W-1:0] c2;
		logic signed [COEF_W-1:0] cd;
	} cfg_t;

endpackage

// ----- design/dc_motor_discrete_speed_model.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dc_motor_discrete_speed_model
// Second-order recursive DC motor speed model, Q8.8 voltage in, Q12.12 out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one voltage word per beat; tuser[0] clears the history.
//   m_* stream: one speed word per input word; tuser[0] flags saturation.
//   cfg_* port: index 0 mode, 1 speed lag-1 coef, 2 lag-2 coef, 3 drive coef.
//     Write only while idle; ready is always high, unknown indexes are dropped.
// Path: an accepted word is held in the input register, then in the output register.
// Throughput: 1 word per cycle unless m_tready stalls. The whole step (three 32-bit
//   multiplies, sum, round, saturate) sits between the input register and the
//   output/history registers, so the speed feedback closes with no extra register.
// Reset: history, coefficients and mode clear to zero; both streams empty.
// Stall: a held output word keeps its value; one more input word is taken
//   into the input register, after which s_tready drops until m_tready.
// ----------------------------------------------------------------------------
module dc_motor_discrete_speed_model (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [15:0]                           s_tdata,  // [15:0] voltage_sample
	input  logic [0:0]                            s_tuser,  // [0] clear_history
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [23:0]                           m_tdata,  // [23:0] speed_sample
	output logic [0:0]                            m_tuser,  // [0] saturated
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dcm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dcm_pkg::COEF_W-1:0]            cfg_data
);

	dcm_pkg::cfg_t cfg;

	logic                                  valid_s1;
	logic signed [dcm_pkg::VOLT_W-1:0]     volt_s1;
	logic                                  clr_s1;
	logic                                  out_valid_q;
	logic signed [dcm_pkg::SPEED_W-1:0]    speed_q;
	logic                                  sat_q;
	logic signed [dcm_pkg::SPEED_W-1:0]    sp1_q;
	logic signed [dcm_pkg::SPEED_W-1:0]    sp2_q;
	logic signed [dcm_pkg::VOLT_W-1:0]     vp1_q;
	logic signed [dcm_pkg::VOLT_W-1:0]     vp2_q;
	logic signed [dcm_pkg::SPEED_W-1:0]    sp1_eff;
	logic signed [dcm_pkg::SPEED_W-1:0]    sp2_eff;
	logic signed [dcm_pkg::VOLT_W-1:0]     vp1_eff;
	logic signed [dcm_pkg::VOLT_W-1:0]     vp2_eff;
	logic signed [dcm_pkg::SPEED_W-1:0]    speed;
	logic                                  sat;
	logic                                  advance;
	logic                                  take;

	dcm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign take     = s_tvalid & s_tready;

	assign sp1_eff = clr_s1 ? '0 : sp1_q;
	assign sp2_eff = clr_s1 ? '0 : sp2_q;
	assign vp1_eff = clr_s1 ? '0 : vp1_q;
	assign vp2_eff = clr_s1 ? '0 : vp2_q;

	dcm_datapath u_dp (
		.cfg   (cfg),
		.volt  (volt_s1),
		.sp1   (sp1_eff),
		.sp2   (sp2_eff),
		.vp1   (vp1_eff),
		.vp2   (vp2_eff),
		.speed (speed),
		.sat   (sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			volt_s1 <= s_tdata;
			clr_s1  <= s_tuser[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			speed_q <= speed;
			sat_q   <= sat;
		end
	end

	// model history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp1_q <= '0;
			sp2_q <= '0;
			vp1_q <= '0;
			vp2_q <= '0;
		end else if (advance) begin
			sp1_q <= speed;
			sp2_q <= sp1_eff;
			vp1_q <= volt_s1;
			vp2_q <= vp1_eff;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = speed_q;
	assign m_tuser  = sat_q;

endmodule

// ----- design/dcm_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_cfg_regs
// Configuration register file: mode and the three Q3.28 coefficients.
// ----------------------------------------------------------------------------
module dcm_cfg_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dcm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dcm_pkg::COEF_W-1:0]            cfg_data,
	output dcm_pkg::cfg_t                         cfg
);

	dcm_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				dcm_pkg::REG_MODE: cfg_q.mode <= cfg_data[dcm_pkg::MODE_W-1:0];
				dcm_pkg::REG_C1:   cfg_q.c1   <= cfg_data;
				dcm_pkg::REG_C2:   cfg_q.c2   <= cfg_data;
				dcm_pkg::REG_CD:   cfg_q.cd   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- design/dcm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_datapath
// One model step: drive term, three products, sum, round and saturate.
// ----------------------------------------------------------------------------
module dcm_datapath (
	input  dcm_pkg::cfg_t                         cfg,
	input  logic signed [dcm_pkg::VOLT_W-1:0]     volt,
	input  logic signed [dcm_pkg::SPEED_W-1:0]    sp1,
	input  logic signed [dcm_pkg::SPEED_W-1:0]    sp2,
	input  logic signed [dcm_pkg::VOLT_W-1:0]     vp1,
	input  logic signed [dcm_pkg::VOLT_W-1:0]     vp2,
	output logic signed [dcm_pkg::SPEED_W-1:0]    speed,
	output logic                                  sat
);

	localparam logic signed [dcm_pkg::Y_W-1:0] Y_MAX =
		dcm_pkg::Y_W'((64'sd1 <<< (dcm_pkg::SPEED_W - 1)) - 64'sd1);
	localparam logic signed [dcm_pkg::Y_W-1:0] Y_MIN =
		dcm_pkg::Y_W'(-(64'sd1 <<< (dcm_pkg::SPEED_W - 1)));
	localparam logic signed [dcm_pkg::ACC_W-1:0] RND_HALF =
		dcm_pkg::ACC_W'(64'sd1 <<< (dcm_pkg::RND_SH - 1));

	logic signed [dcm_pkg::DRIVE_W-1:0]                     drive;
	logic signed [dcm_pkg::DRIVE12_W-1:0]                   drive12;
	logic signed [dcm_pkg::COEF_W+dcm_pkg::SPEED_W-1:0]     p1;
	logic signed [dcm_pkg::COEF_W+dcm_pkg::SPEED_W-1:0]     p2;
	logic signed [dcm_pkg::COEF_W+dcm_pkg::DRIVE12_W-1:0]   p3;
	logic signed [dcm_pkg::ACC_W-1:0]                       acc;
	logic signed [dcm_pkg::ACC_W-1:0]                       rnd;
	logic signed [dcm_pkg::Y_W-1:0]                         y;
	logic                                                   sat_hi;
	logic                                                   sat_lo;

	always_comb begin
		if (cfg.mode[1]) begin
			drive = dcm_pkg::DRIVE_W'(volt) + (dcm_pkg::DRIVE_W'(vp1) <<< 1)
				+ dcm_pkg::DRIVE_W'(vp2);
		end else if (cfg.mode == dcm_pkg::MODE_BWD_EULER) begin
			drive = dcm_pkg::DRIVE_W'(volt);
		end else begin
			drive = dcm_pkg::DRIVE_W'(vp2);
		end
	end

	// Q8.8 to Q12.12
	assign drive12 = {drive, 4'b0000};

	assign p1 = cfg.c1 * sp1;
	assign p2 = cfg.c2 * sp2;
	assign p3 = cfg.cd * drive12;

	assign acc = dcm_pkg::ACC_W'(p1) + dcm_pkg::ACC_W'(p2) + dcm_pkg::ACC_W'(p3);
	assign rnd = acc + RND_HALF;
	assign y   = rnd[dcm_pkg::ACC_W-1:dcm_pkg::RND_SH];

	assign sat_hi = (y > Y_MAX);
	assign sat_lo = (y < Y_MIN);
	assign sat    = sat_hi | sat_lo;

	always_comb begin
		if (sat_hi) begin
			speed = Y_MAX[dcm_pkg::SPEED_W-1:0];
		end else if (sat_lo) begin
			speed = Y_MIN[dcm_pkg::SPEED_W-1:0];
		end else begin
			speed = y[dcm_pkg::SPEED_W-1:0];
		end
	end

endmodule

// ----- design/dcm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_checker
// Port-level checks of the motor model, bound to the top level.
// ----------------------------------------------------------------------------
module dcm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic [0:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == 24'h7fffff) || (m_tdata == 24'h800000))
		else $error("saturation flag without clipped speed");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output word without matching input two cycles earlier");

endmodule

bind dc_motor_discrete_speed_model dcm_checker u_dcm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- sim/dc_motor_discrete_speed_model_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dc_motor_discrete_speed_model_check
// Watches the motor model's ports, forecasts each speed word and compares.
// Register writes update a private copy of the coefficients. Every accepted
// voltage word runs through an independent fixed-point recursion, and the
// result is queued. Each accepted speed word is checked against the oldest
// forecast, speed and saturation flag separately.
// ----------------------------------------------------------------------------
module dc_motor_discrete_speed_model_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [15:0]                   s_tdata,  // [15:0] voltage_sample
	input  logic [0:0]                    s_tuser,  // [0] clear_history
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [23:0]                   m_tdata,  // [23:0] speed_sample
	input  logic [0:0]                    m_tuser,  // [0] saturated
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [dcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dcm_pkg::COEF_W-1:0]    cfg_data,
	output int unsigned                   fails,
	output int unsigned                   pending
);

	localparam longint SPD_MAX = (longint'(1) << (dcm_pkg::SPEED_W - 1)) - 1;
	localparam longint SPD_MIN = -(longint'(1) << (dcm_pkg::SPEED_W - 1));

	typedef struct packed {
		logic [dcm_pkg::SPEED_W-1:0] speed;
		logic                        sat;
	} speed_word_t;

	dcm_pkg::cfg_t                      coefs;
	logic signed [dcm_pkg::SPEED_W-1:0] spd_z1, spd_z2;
	logic signed [dcm_pkg::VOLT_W-1:0]  volt_z1, volt_z2;
	speed_word_t                        speed_forecast[$];
	speed_word_t                        due;
	int unsigned                        errs;

	function automatic speed_word_t model_speed(logic signed [dcm_pkg::VOLT_W-1:0] v,
		logic clr);
		longint      drive;
		longint      acc;
		longint      y;
		speed_word_t r;
		if (clr) begin
			spd_z1  = '0;
			spd_z2  = '0;
			volt_z1 = '0;
			volt_z2 = '0;
		end
		if ((coefs.mode & dcm_pkg::MODE_TUSTIN) != '0) begin
			drive = longint'(v) + 2 * longint'(volt_z1) + longint'(volt_z2);
		end else if (coefs.mode == dcm_pkg::MODE_BWD_EULER) begin
			drive = longint'(v);
		end else begin
			drive = longint'(volt_z2);
		end
		drive = drive * 16;
		acc = longint'(coefs.c1) * longint'(spd_z1)
			+ longint'(coefs.c2) * longint'(spd_z2)
			+ longint'(coefs.cd) * drive;
		y = (acc + (longint'(1) << (dcm_pkg::RND_SH - 1))) >>> dcm_pkg::RND_SH;
		r.sat = 1'b0;
		if (y > SPD_MAX) begin
			y = SPD_MAX;
			r.sat = 1'b1;
		end
		if (y < SPD_MIN) begin
			y = SPD_MIN;
			r.sat = 1'b1;
		end
		r.speed = y[dcm_pkg::SPEED_W-1:0];
		spd_z2  = spd_z1;
		spd_z1  = y[dcm_pkg::SPEED_W-1:0];
		volt_z2 = volt_z1;
		volt_z1 = v;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs   = '0;
			spd_z1  = '0;
			spd_z2  = '0;
			volt_z1 = '0;
			volt_z2 = '0;
			errs    = 0;
			speed_forecast.delete();
			fails   <= 0;
			pending <= 0;
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					dcm_pkg::REG_MODE: coefs.mode = cfg_data[dcm_pkg::MODE_W-1:0];
					dcm_pkg::REG_C1:   coefs.c1   = cfg_data;
					dcm_pkg::REG_C2:   coefs.c2   = cfg_data;
					dcm_pkg::REG_CD:   coefs.cd   = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (speed_forecast.size() == 0) begin
					$display("%0t: unexpected speed word %h sat %b", $time, m_tdata, m_tuser[0]);
					errs = errs + 1;
				end else begin
					due = speed_forecast.pop_front();
					if (m_tdata !== due.speed) begin
						$display("%0t: speed mismatch, expected %h got %h",
							$time, due.speed, m_tdata);
						errs = errs + 1;
					end
					if (m_tuser[0] !== due.sat) begin
						$display("%0t: saturation flag mismatch, expected %b got %b",
							$time, due.sat, m_tuser[0]);
						errs = errs + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				speed_forecast.push_back(model_speed(s_tdata, s_tuser[0]));
			fails   <= fails + errs;
			pending <= speed_forecast.size();
		end
	end

endmodule

// ----- sim/dc_motor_discrete_speed_model_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dc_motor_discrete_speed_model_test
// Stimulus and verdict for the motor speed model.
// A directed pass drives voltage extremes, clears and saturation through every
// discretization mode, then randomized phases reload the coefficients and
// stream voltage words under changing source gaps and sink stalls.
// ----------------------------------------------------------------------------
module dc_motor_discrete_speed_model_test;

	localparam int                   DUT_LATENCY  = 2;
	localparam int unsigned          CYCLE_LIMIT  = 200000;
	localparam int                   RAND_PHASES  = 12;
	localparam int                   PHASE_ITEMS  = 94;
	localparam logic [dcm_pkg::CFG_IDX_W-1:0] FIRST_UNUSED_REG = dcm_pkg::REG_CD + 1'b1;
	localparam logic signed [dcm_pkg::COEF_W-1:0] C1_NOMINAL = 32'sd483183821;   // 1.8
	localparam logic signed [dcm_pkg::COEF_W-1:0] C2_NOMINAL = -32'sd217432719;  // -0.81
	localparam logic signed [dcm_pkg::COEF_W-1:0] CD_QUARTER = 32'sd67108864;    // 0.25
	localparam logic signed [dcm_pkg::COEF_W-1:0] COEF_MIN   = 32'sh80000000;
	localparam logic signed [dcm_pkg::COEF_W-1:0] COEF_MAX   = 32'sh7FFFFFFF;
	localparam logic [15:0] DIR_VOLTS [6] = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
		16'h0000, 16'hFFFF};
	localparam logic        DIR_CLR   [6] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [15:0]                   s_tdata   = '0;
	logic [0:0]                    s_tuser   = '0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [23:0]                   m_tdata;
	logic [0:0]                    m_tuser;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [dcm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [dcm_pkg::COEF_W-1:0]    cfg_data  = '0;

	int unsigned fails;
	int unsigned pending;
	int unsigned cycle_count   = 0;
	int          send_gap_pct  = 8;
	int          recv_stall_pct = 45;

	dc_motor_discrete_speed_model dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dc_motor_discrete_speed_model_check checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(input logic [dcm_pkg::CFG_IDX_W-1:0] idx,
		input logic [dcm_pkg::COEF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic load_coefs(input dcm_pkg::cfg_t c, input logic stray_write);
		write_reg(dcm_pkg::REG_MODE, {30'($urandom), c.mode});
		write_reg(dcm_pkg::REG_C1, c.c1);
		write_reg(dcm_pkg::REG_C2, c.c2);
		write_reg(dcm_pkg::REG_CD, c.cd);
		if (stray_write)
			write_reg(dcm_pkg::CFG_IDX_W'($urandom_range(255, FIRST_UNUSED_REG)), $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_word(input logic [15:0] volts, input logic clr);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= volts;
		s_tuser  <= clr;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// drop valid and let every forecast speed word arrive
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DUT_LATENCY + 2) @(posedge clk);
	endtask

	initial begin
		dcm_pkg::cfg_t      c;
		logic signed [15:0] volts;
		logic               clr;
		int                 pick;
		volts = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each mode, voltage extremes, clears, then hard saturation
		for (int m = 0; m < 4; m++) begin
			if (m == 3) begin
				c = '{mode: dcm_pkg::MODE_TUSTIN | dcm_pkg::MODE_BWD_EULER, c1: COEF_MIN,
					c2: COEF_MAX, cd: COEF_MAX};
			end else begin
				c = '{mode: dcm_pkg::MODE_W'(m), c1: C1_NOMINAL, c2: C2_NOMINAL,
					cd: CD_QUARTER};
			end
			load_coefs(c, m == 1);
			for (int i = 0; i < 6; i++)
				send_word(DIR_VOLTS[i], DIR_CLR[i]);
			drain();
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p < 4) begin
				send_gap_pct   = 8;
				recv_stall_pct = 45;
			end else if (p < 8) begin
				send_gap_pct   = 45;
				recv_stall_pct = 8;
			end else begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
			c.mode = dcm_pkg::MODE_W'(p % 4);
			if (p % 5 == 4) begin
				c.c1 = $urandom;
				c.c2 = $urandom;
				c.cd = $urandom;
			end else begin
				c.c1 = C1_NOMINAL + dcm_pkg::COEF_W'($urandom_range(1 << 20)) - (32'sd1 <<< 19);
				c.c2 = C2_NOMINAL + dcm_pkg::COEF_W'($urandom_range(1 << 20)) - (32'sd1 <<< 19);
				c.cd = dcm_pkg::COEF_W'($urandom_range(1 << 26)) - (32'sd1 <<< 25);
			end
			load_coefs(c, p % 3 == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p % 3 == 1 && i == PHASE_ITEMS / 2)
					drain();
				pick = $urandom_range(9);
				if (pick < 5)
					volts = 16'($urandom);
				else if (pick < 8)
					volts = 16'($urandom_range(2047)) - 16'sd1024;
				clr = ($urandom_range(31) == 0);
				send_word(volts, clr);
			end
			drain();
		end

		repeat (4 * DUT_LATENCY) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/dcm_pkg.sv
design/dcm_cfg_regs.sv
design/dcm_datapath.sv
design/dc_motor_discrete_speed_model.sv
design/dcm_checker.sv
sim/dc_motor_discrete_speed_model_check.sv
sim/dc_motor_discrete_speed_model_test.sv
